// ===== sv/pcm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcm_pkg: shared types and constants
// Field widths, status codes, register indexes and the coefficient set
// of the perspective coordinate map.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int COORD_W   = 12;
    localparam int COEF_W    = 32;
    localparam int MAP_W     = 24;
    localparam int RND_W     = 16;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 4;

    // quotient magnitude bits; the magnitude is clamped to 2^QLIM_EXP
    localparam int QB        = 41;
    localparam int QLIM_EXP  = 40;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_H00 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_H01 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_H02 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_H10 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_H11 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_H12 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_H20 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_H21 = 4'd7;

    localparam logic [COEF_W-1:0] COEF_ONE_Q20 = 32'd1048576;

    typedef struct packed {
        logic signed [COEF_W-1:0] h00;
        logic signed [COEF_W-1:0] h01;
        logic signed [COEF_W-1:0] h02;
        logic signed [COEF_W-1:0] h10;
        logic signed [COEF_W-1:0] h11;
        logic signed [COEF_W-1:0] h12;
        logic signed [COEF_W-1:0] h20;
        logic signed [COEF_W-1:0] h21;
    } pcm_coef_t;

    // sideband that travels with every pipeline stage
    typedef struct packed {
        logic vld;
        logic zero;
    } pcm_tag_t;

endpackage

// ===== sv/pcm_ifs.sv =====
// ----------------------------------------------------------------------------
// pcm_ifs: channel interfaces
// Coordinate input, mapped result output and register write channels.
// ----------------------------------------------------------------------------
interface pcm_coord_if;
    import pcm_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    modport source (output valid, col, row, input ready);
    modport sink   (input valid, col, row, output ready);
endinterface

interface pcm_result_if;
    import pcm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [MAP_W-1:0]  map_x;
    logic signed [MAP_W-1:0]  map_y;
    logic signed [RND_W-1:0]  round_x;
    logic signed [RND_W-1:0]  round_y;
    logic [STAT_W-1:0]        status;
    modport source (output valid, map_x, map_y, round_x, round_y, status, input ready);
    modport sink   (input valid, map_x, map_y, round_x, round_y, status, output ready);
endinterface

interface pcm_cfg_if;
    import pcm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/pcm_mac.sv =====
// ----------------------------------------------------------------------------
// pcm_mac: projective numerators and denominator
// Three stages: products, sums, then sign and magnitude split.
// ----------------------------------------------------------------------------
module pcm_mac #(
    parameter int CB = 12,
    parameter int SW = 47
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_vld,
    input  logic [CB-1:0]     c,
    input  logic [CB-1:0]     r,
    input  pcm_pkg::pcm_coef_t coef,
    output pcm_pkg::pcm_tag_t tag,
    output logic              x_neg,
    output logic              y_neg,
    output logic [SW-1:0]     x_mag,
    output logic [SW-1:0]     y_mag,
    output logic [SW-1:0]     d_mag
);
    import pcm_pkg::*;

    localparam int PW = CB + 33;
    localparam logic signed [SW-1:0] ONE_Q30 = SW'(1) <<< 30;

    logic signed [CB:0]    cs, rs;
    logic signed [PW-1:0]  p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic signed [SW-1:0]  nx_reg, ny_reg, den_reg;
    logic                  v1_reg, v2_reg, v3_reg, zero_reg;
    logic [SW-1:0]         xm_reg, ym_reg, dm_reg;
    logic                  xn_reg, yn_reg;

    assign cs = {1'b0, c};
    assign rs = {1'b0, r};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg <= PW'(coef.h00) * PW'(cs);
            p01_reg <= PW'(coef.h01) * PW'(rs);
            p10_reg <= PW'(coef.h10) * PW'(cs);
            p11_reg <= PW'(coef.h11) * PW'(rs);
            p20_reg <= PW'(coef.h20) * PW'(cs);
            p21_reg <= PW'(coef.h21) * PW'(rs);

            nx_reg  <= SW'(p00_reg) + SW'(p01_reg) + (SW'(coef.h02) <<< 4);
            ny_reg  <= SW'(p10_reg) + SW'(p11_reg) + (SW'(coef.h12) <<< 4);
            den_reg <= SW'(p20_reg) + SW'(p21_reg) + ONE_Q30;

            xm_reg   <= nx_reg[SW-1] ? unsigned'(-nx_reg) : unsigned'(nx_reg);
            ym_reg   <= ny_reg[SW-1] ? unsigned'(-ny_reg) : unsigned'(ny_reg);
            dm_reg   <= den_reg[SW-1] ? unsigned'(-den_reg) : unsigned'(den_reg);
            xn_reg   <= nx_reg[SW-1] ^ den_reg[SW-1];
            yn_reg   <= ny_reg[SW-1] ^ den_reg[SW-1];
            zero_reg <= (den_reg == '0);
        end
    end

    assign tag.vld  = v3_reg;
    assign tag.zero = zero_reg;
    assign x_neg    = xn_reg;
    assign y_neg    = yn_reg;
    assign x_mag    = xm_reg;
    assign y_mag    = ym_reg;
    assign d_mag    = dm_reg;

endmodule

// ===== sv/pcm_div.sv =====
// ----------------------------------------------------------------------------
// pcm_div: pipelined restoring divider
// One quotient bit per stage, then round half away and clamp.
// ----------------------------------------------------------------------------
module pcm_div #(
    parameter int SW = 47,
    parameter int S  = 18
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  pcm_pkg::pcm_tag_t        tag_in,
    input  logic                     neg_in,
    input  logic [SW-1:0]            mag_in,
    input  logic [SW-1:0]            d_in,
    output pcm_pkg::pcm_tag_t        tag_out,
    output logic                     neg_out,
    output logic [pcm_pkg::QB-1:0]   q_out
);
    import pcm_pkg::*;

    localparam int NW = SW + S;
    localparam logic [QB:0] QLIM = (QB+1)'(1) << QLIM_EXP;

    logic [NW-1:0]  num;
    logic [SW-1:0]  r_reg   [0:QB];
    logic [SW-1:0]  d_reg   [0:QB];
    logic [QB-1:0]  lo_reg  [0:QB];
    logic [QB-1:0]  q_reg   [0:QB];
    logic           neg_reg [0:QB];
    logic           ovf_reg [0:QB];
    pcm_tag_t       tag_reg [0:QB];

    logic [QB:0]    qr;
    logic           clamp;
    pcm_tag_t       tag_o_reg;
    logic           neg_o_reg;
    logic [QB-1:0]  q_o_reg;

    // dividend is the magnitude scaled by 2^S; anything above the
    // quotient range shows up as high bits not below the divisor
    assign num = {mag_in, {S{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (adv)
        begin
            tag_reg[0] <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0]   <= SW'(num[NW-1:QB]);
            ovf_reg[0] <= SW'(num[NW-1:QB]) >= d_in;
            lo_reg[0]  <= num[QB-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= d_in;
            neg_reg[0] <= neg_in;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [SW:0] t;
        logic        ge;

        assign t  = {r_reg[k], lo_reg[k][QB-1]};
        assign ge = t >= {1'b0, d_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k+1] <= '0;
            end
            else if (adv)
            begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[k+1]   <= ge ? SW'(t - {1'b0, d_reg[k]}) : SW'(t);
                q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
                lo_reg[k+1]  <= lo_reg[k] << 1;
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign qr    = {1'b0, q_reg[QB]}
                 + (QB+1)'({r_reg[QB], 1'b0} >= {1'b0, d_reg[QB]});
    assign clamp = ovf_reg[QB] || (qr > QLIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_o_reg <= '0;
        end
        else if (adv)
        begin
            tag_o_reg <= tag_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_o_reg   <= clamp ? QLIM[QB-1:0] : qr[QB-1:0];
            neg_o_reg <= neg_reg[QB];
        end
    end

    assign tag_out = tag_o_reg;
    assign neg_out = neg_o_reg;
    assign q_out   = q_o_reg;

endmodule

// ===== sv/pcm_fmt.sv =====
// ----------------------------------------------------------------------------
// pcm_fmt: output formatting
// Apply sign, round half to even, saturate, and hold the output register.
// ----------------------------------------------------------------------------
module pcm_fmt #(
    parameter int F = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  pcm_pkg::pcm_tag_t             tag,
    input  logic                          x_neg,
    input  logic [pcm_pkg::QB-1:0]        x_mag,
    input  logic                          y_neg,
    input  logic [pcm_pkg::QB-1:0]        y_mag,
    output logic                          vld,
    output logic signed [pcm_pkg::MAP_W-1:0] map_x,
    output logic signed [pcm_pkg::MAP_W-1:0] map_y,
    output logic signed [pcm_pkg::RND_W-1:0] round_x,
    output logic signed [pcm_pkg::RND_W-1:0] round_y,
    output logic [pcm_pkg::STAT_W-1:0]    status
);
    import pcm_pkg::*;

    localparam logic [F-1:0] HALF = F'(1) << (F - 1);
    localparam logic signed [QB:0] MAP_MAX = (QB+1)'((1 <<< (MAP_W - 1)) - 1);
    localparam logic signed [QB:0] MAP_MIN = (QB+1)'(-(1 <<< (MAP_W - 1)));
    localparam logic signed [QB:0] RND_MAX = (QB+1)'((1 <<< (RND_W - 1)) - 1);
    localparam logic signed [QB:0] RND_MIN = (QB+1)'(-(1 <<< (RND_W - 1)));

    function automatic logic signed [QB:0] rnd_even(input logic signed [QB:0] v);
        logic signed [QB:0] fl;
        logic [F-1:0]       fr;
        logic               inc;
        begin
            fl  = v >>> F;
            fr  = v[F-1:0];
            inc = (fr > HALF) || ((fr == HALF) && fl[0]);
            rnd_even = fl + (QB+1)'(inc);
        end
    endfunction

    logic signed [QB:0]      sx, sy;
    logic signed [QB:0]      vx_reg, vy_reg;
    pcm_tag_t                tag_reg;
    logic signed [QB:0]      rx, ry;
    logic                    hmx, hmy, hrx, hry;
    logic                    vld_reg;
    logic signed [MAP_W-1:0] mx_reg, my_reg;
    logic signed [RND_W-1:0] rx_reg, ry_reg;
    logic [STAT_W-1:0]       st_reg;
    logic signed [MAP_W-1:0] mx_next, my_next;
    logic signed [RND_W-1:0] rx_next, ry_next;
    logic [STAT_W-1:0]       st_next;

    assign sx = {1'b0, x_mag};
    assign sy = {1'b0, y_mag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            tag_reg <= tag;
            vld_reg <= tag_reg.vld;
        end
    end

    always_comb
    begin
        rx  = rnd_even(vx_reg);
        ry  = rnd_even(vy_reg);
        hmx = (vx_reg > MAP_MAX) || (vx_reg < MAP_MIN);
        hmy = (vy_reg > MAP_MAX) || (vy_reg < MAP_MIN);
        hrx = (rx > RND_MAX) || (rx < RND_MIN);
        hry = (ry > RND_MAX) || (ry < RND_MIN);
        mx_next = hmx ? (vx_reg[QB] ? MAP_MIN[MAP_W-1:0] : MAP_MAX[MAP_W-1:0])
                      : vx_reg[MAP_W-1:0];
        my_next = hmy ? (vy_reg[QB] ? MAP_MIN[MAP_W-1:0] : MAP_MAX[MAP_W-1:0])
                      : vy_reg[MAP_W-1:0];
        rx_next = hrx ? (rx[QB] ? RND_MIN[RND_W-1:0] : RND_MAX[RND_W-1:0])
                      : rx[RND_W-1:0];
        ry_next = hry ? (ry[QB] ? RND_MIN[RND_W-1:0] : RND_MAX[RND_W-1:0])
                      : ry[RND_W-1:0];
        st_next = (hmx || hmy || hrx || hry) ? ST_SAT : ST_OK;
        if (tag_reg.zero)
        begin
            mx_next = '0;
            my_next = '0;
            rx_next = '0;
            ry_next = '0;
            st_next = ST_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg <= x_neg ? -sx : sx;
            vy_reg <= y_neg ? -sy : sy;
            mx_reg <= mx_next;
            my_reg <= my_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            st_reg <= st_next;
        end
    end

    assign vld     = vld_reg;
    assign map_x   = mx_reg;
    assign map_y   = my_reg;
    assign round_x = rx_reg;
    assign round_y = ry_reg;
    assign status  = st_reg;

endmodule

// ===== sv/perspective_coordinate_map_unit.sv =====
// ----------------------------------------------------------------------------
// perspective_coordinate_map_unit: homography point transform
// Maps a pixel (col, row) through a normalized 3x3 homography to fixed
// point and rounded integer coordinates with saturation status.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  coord   | in  | valid/ready   | col, row
//  result  | out | valid/ready   | map_x, map_y, round_x, round_y, status
//  cfg     | in  | valid/ready   | index, data (ready is always high)
//
//  One transaction per clock while results are taken; the stages run:
//  products and sums, the divider (one quotient bit per stage, 41 bits,
//  plus setup and rounding), then formatting.
//  The whole pipeline advances together; when a result waits at the
//  output register, every stage holds and coord.ready drops.
//  Reset clears the valid bits and loads identity coefficients.
// ----------------------------------------------------------------------------
module perspective_coordinate_map_unit #(
    parameter int COORD_BITS    = 12,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    pcm_coord_if.sink    coord,
    pcm_result_if.source result,
    pcm_cfg_if.sink      cfg
);
    import pcm_pkg::*;

    // only the low coordinate bits take part, at most the field width
    localparam int CB = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int SW = CB + 35;
    localparam int S  = OUT_FRAC_BITS + 10;

    pcm_coef_t         coef_reg;
    logic              adv;
    pcm_tag_t          m_tag, x_tag, y_tag;
    logic              m_xneg, m_yneg;
    logic [SW-1:0]     m_xmag, m_ymag, m_dmag;
    logic              x_neg, y_neg;
    logic [QB-1:0]     x_q, y_q;

    // register writes; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '{h00: COEF_ONE_Q20, h11: COEF_ONE_Q20, default: '0};
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_H00: coef_reg.h00 <= cfg.data;
                REG_H01: coef_reg.h01 <= cfg.data;
                REG_H02: coef_reg.h02 <= cfg.data;
                REG_H10: coef_reg.h10 <= cfg.data;
                REG_H11: coef_reg.h11 <= cfg.data;
                REG_H12: coef_reg.h12 <= cfg.data;
                REG_H20: coef_reg.h20 <= cfg.data;
                REG_H21: coef_reg.h21 <= cfg.data;
                default: ;
            endcase
        end
    end

    // advance the pipeline unless a result waits untaken
    assign adv         = !result.valid || result.ready;
    assign coord.ready = adv;

    pcm_mac #(.CB(CB), .SW(SW)) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_vld (coord.valid),
        .c      (coord.col[CB-1:0]),
        .r      (coord.row[CB-1:0]),
        .coef   (coef_reg),
        .tag    (m_tag),
        .x_neg  (m_xneg),
        .y_neg  (m_yneg),
        .x_mag  (m_xmag),
        .y_mag  (m_ymag),
        .d_mag  (m_dmag)
    );

    // x and y lanes share the denominator and run in lockstep
    pcm_div #(.SW(SW), .S(S)) u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_in  (m_tag),
        .neg_in  (m_xneg),
        .mag_in  (m_xmag),
        .d_in    (m_dmag),
        .tag_out (x_tag),
        .neg_out (x_neg),
        .q_out   (x_q)
    );

    pcm_div #(.SW(SW), .S(S)) u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_in  (m_tag),
        .neg_in  (m_yneg),
        .mag_in  (m_ymag),
        .d_in    (m_dmag),
        .tag_out (y_tag),
        .neg_out (y_neg),
        .q_out   (y_q)
    );

    pcm_fmt #(.F(OUT_FRAC_BITS)) u_fmt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag     (x_tag),
        .x_neg   (x_neg),
        .x_mag   (x_q),
        .y_neg   (y_neg),
        .y_mag   (y_q),
        .vld     (result.valid),
        .map_x   (result.map_x),
        .map_y   (result.map_y),
        .round_x (result.round_x),
        .round_y (result.round_y),
        .status  (result.status)
    );

    // lanes never drift apart
    a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
        x_tag == y_tag)
        else $error("x and y divider lanes out of step");

    // a waiting result stalls the input side
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !coord.ready)
        else $error("input accepted while output stalled");

    // zero denominator results carry zero coordinates
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_ZERO) |->
        (result.map_x == '0 && result.map_y == '0 &&
         result.round_x == '0 && result.round_y == '0))
        else $error("zero denominator with nonzero coordinates");

    // clamped quotient magnitude never exceeds the limit
    a_q_limit: assert property (@(posedge clk) disable iff (!rst_n)
        x_tag.vld |-> (x_q <= (QB'(1) << QLIM_EXP)))
        else $error("quotient above clamp limit");

endmodule
